// ----- src/fim_pkg.sv -----
// ----------------------------------------------------------------------------
// fim_pkg: shared types and constants of the frame interval monitor
// Event kinds, sequencer states and the fixed field widths.
// ----------------------------------------------------------------------------
package fim_pkg;

	localparam int STAMP_W = 64;
	localparam int TICK_W  = 40;
	localparam int RATE_W  = 16;
	localparam int TREG_W  = 32;
	localparam int ACC_W   = 41;

	localparam logic [TREG_W-1:0] TICK_RATE_RESET = 32'd10000000;
	localparam logic [TICK_W-1:0] TICK_MAX        = {TICK_W{1'b1}};
	localparam logic [RATE_W-1:0] RATE_MAX        = {RATE_W{1'b1}};

	typedef enum logic [1:0] {
		KIND_FRAME  = 2'd0,
		KIND_RESET  = 2'd1,
		KIND_RESUME = 2'd2,
		KIND_STOP   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CTRL,
		ST_INTERVAL,
		ST_FILTER,
		ST_UPDATE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

endpackage

// ----- src/fim_channels.sv -----
// ----------------------------------------------------------------------------
// fim channels: request and result interfaces of the frame interval monitor
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fim_evt_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  kind;
	logic [fim_pkg::STAMP_W-1:0] timestamp;

	modport source (output valid, kind, timestamp, input ready);
	modport sink (input valid, kind, timestamp, output ready);
endinterface

interface fim_res_if;
	logic                        valid;
	logic                        ready;
	logic [fim_pkg::TICK_W-1:0]  elapsed_ticks;
	logic [fim_pkg::TICK_W-1:0]  average_ticks;
	logic [fim_pkg::RATE_W-1:0]  frame_rate;
	logic [fim_pkg::STAMP_W-1:0] total_ticks;
	logic                        is_stopped;

	modport source (output valid, elapsed_ticks, average_ticks, frame_rate, total_ticks,
		is_stopped, input ready);
	modport sink (input valid, elapsed_ticks, average_ticks, frame_rate, total_ticks,
		is_stopped, output ready);
endinterface

// ----- src/frame_interval_monitor.sv -----
// ----------------------------------------------------------------------------
// frame_interval_monitor: frame interval, moving average and frame rate
// Measures frame intervals from timestamps, keeps a window of recent
// intervals with their mean, latches a frame rate per second of time and
// tracks paused time between stop and resume requests.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  evt       in         kind, timestamp
//  res       out        elapsed_ticks, average_ticks, frame_rate,
//                       total_ticks, is_stopped
//  cfg       in         cfg_wr_en, cfg_wr_data (tick_rate)
//
// A reset, resume or stop request passes through the control state to the
// done state; a new request is taken only after the sequencer returns to idle.
// A frame request passes through the interval, filter and update states and
// then the bit-serial divider that forms the window average, which produces
// the SUM_W quotient bits one after another. With an empty window the
// divider is skipped and the frame goes straight to the done state.
// One request is in work at a time; evt.ready is high only in the idle state.
// A result waits in the output register while the next request is accepted;
// the next result stalls until that one is taken.
// arst_n clears all but win_mem and result data; tick_rate resets to ten million.
// ----------------------------------------------------------------------------
module frame_interval_monitor #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fim_evt_if.sink                     evt,
	fim_res_if.source                   res,
	input  logic                        cfg_wr_en,
	input  logic [fim_pkg::TREG_W-1:0]  cfg_wr_data
);

	localparam int HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = fim_pkg::TICK_W + $clog2(WINDOW_DEPTH);

	fim_pkg::state_t state_q, state_d;

	logic [fim_pkg::TREG_W-1:0]  tick_rate_q;
	fim_pkg::kind_t              kind_q;
	logic [fim_pkg::STAMP_W-1:0] ts_q;

	logic [fim_pkg::TICK_W-1:0]  win_mem [WINDOW_DEPTH];
	logic [fim_pkg::TICK_W-1:0]  win_rd_q;
	logic [HEAD_W-1:0]           head_q;
	logic [SUM_W-1:0]            sum_q;
	logic [CNT_W-1:0]            count_q;
	logic [fim_pkg::TICK_W-1:0]  avg_q;
	logic [fim_pkg::TICK_W-1:0]  elapsed_q;
	logic                        take_q;

	logic [fim_pkg::STAMP_W-1:0] last_q;
	logic [fim_pkg::STAMP_W-1:0] current_q;
	logic [fim_pkg::STAMP_W-1:0] base_q;
	logic [fim_pkg::STAMP_W-1:0] stop_q;
	logic [fim_pkg::STAMP_W-1:0] paused_q;
	logic                        stopped_q;
	logic [fim_pkg::RATE_W-1:0]  frames_q;
	logic [fim_pkg::ACC_W-1:0]   accum_q;
	logic [fim_pkg::RATE_W-1:0]  rate_q;

	logic                        res_valid_q;
	logic [fim_pkg::TICK_W-1:0]  res_elapsed_q;
	logic [fim_pkg::TICK_W-1:0]  res_avg_q;
	logic [fim_pkg::RATE_W-1:0]  res_rate_q;
	logic [fim_pkg::STAMP_W-1:0] res_total_q;
	logic                        res_stopped_q;

	logic                        accept;
	logic                        div_start;
	logic                        div_done;
	logic [SUM_W-1:0]            div_quot;
	logic                        load_res;

	logic [fim_pkg::STAMP_W-1:0] delta;
	logic [fim_pkg::TICK_W-1:0]  delta_sat;
	logic [fim_pkg::TICK_W-1:0]  gap;
	logic [fim_pkg::ACC_W-1:0]   accum_next;
	logic [fim_pkg::RATE_W-1:0]  frames_next;
	logic                        window_full;
	logic [fim_pkg::STAMP_W-1:0] total;

	assign accept = evt.valid && evt.ready;

	// Interval since the previous frame, clamped to the field width.
	assign delta     = ts_q - last_q;
	assign delta_sat = (|delta[fim_pkg::STAMP_W-1:fim_pkg::TICK_W]) ? fim_pkg::TICK_MAX :
		delta[fim_pkg::TICK_W-1:0];
	assign gap = (elapsed_q >= avg_q) ? elapsed_q - avg_q : avg_q - elapsed_q;

	assign accum_next  = accum_q + fim_pkg::ACC_W'(elapsed_q);
	assign frames_next = (frames_q == fim_pkg::RATE_MAX) ? frames_q :
		frames_q + fim_pkg::RATE_W'(1);
	assign window_full = count_q == CNT_W'(WINDOW_DEPTH);
	assign total = (stopped_q ? stop_q : current_q) - paused_q - base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fim_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		evt.ready = 1'b0;
		div_start = 1'b0;
		load_res  = 1'b0;
		unique case (state_q)
			fim_pkg::ST_IDLE: begin
				evt.ready = 1'b1;
				if (evt.valid) begin
					state_d = (fim_pkg::kind_t'(evt.kind) == fim_pkg::KIND_FRAME) ?
						fim_pkg::ST_INTERVAL : fim_pkg::ST_CTRL;
				end
			end
			fim_pkg::ST_CTRL:      state_d = fim_pkg::ST_DONE;
			fim_pkg::ST_INTERVAL:  state_d = fim_pkg::ST_FILTER;
			fim_pkg::ST_FILTER:    state_d = fim_pkg::ST_UPDATE;
			fim_pkg::ST_UPDATE:    state_d = fim_pkg::ST_DIV_START;
			fim_pkg::ST_DIV_START: begin
				if (count_q == '0) begin
					state_d = fim_pkg::ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = fim_pkg::ST_DIV_WAIT;
				end
			end
			fim_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = fim_pkg::ST_DONE;
				end
			end
			fim_pkg::ST_DONE: begin
				if (!res_valid_q || res.ready) begin
					load_res = 1'b1;
					state_d  = fim_pkg::ST_IDLE;
				end
			end
			default: state_d = fim_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= fim_pkg::TICK_RATE_RESET;
			kind_q      <= fim_pkg::KIND_FRAME;
			ts_q        <= '0;
			head_q      <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			avg_q       <= '0;
			elapsed_q   <= '0;
			take_q      <= 1'b0;
			last_q      <= '0;
			current_q   <= '0;
			base_q      <= '0;
			stop_q      <= '0;
			paused_q    <= '0;
			stopped_q   <= 1'b0;
			frames_q    <= '0;
			accum_q     <= '0;
			rate_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tick_rate_q <= cfg_wr_data;
			end
			if (accept) begin
				kind_q <= fim_pkg::kind_t'(evt.kind);
				ts_q   <= evt.timestamp;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				fim_pkg::ST_CTRL: begin
					case (kind_q)
						fim_pkg::KIND_RESET: begin
							base_q    <= ts_q;
							last_q    <= ts_q;
							stop_q    <= '0;
							stopped_q <= 1'b0;
							paused_q  <= '0;
						end
						fim_pkg::KIND_RESUME: begin
							if (stopped_q) begin
								paused_q  <= paused_q + (ts_q - stop_q);
								last_q    <= ts_q;
								stop_q    <= '0;
								stopped_q <= 1'b0;
							end
						end
						fim_pkg::KIND_STOP: begin
							if (!stopped_q) begin
								stop_q    <= ts_q;
								stopped_q <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				fim_pkg::ST_INTERVAL: begin
					elapsed_q <= delta_sat;
					current_q <= ts_q;
					last_q    <= ts_q;
				end
				fim_pkg::ST_FILTER: begin
					take_q <= gap < fim_pkg::TICK_W'(tick_rate_q);
					// The rate window closes once its time passes one second.
					if (accum_next > fim_pkg::ACC_W'(tick_rate_q)) begin
						rate_q   <= frames_next;
						frames_q <= '0;
						accum_q  <= '0;
					end else begin
						frames_q <= frames_next;
						accum_q  <= accum_next;
					end
				end
				fim_pkg::ST_UPDATE: begin
					if (take_q) begin
						if (window_full) begin
							sum_q <= sum_q - SUM_W'(win_rd_q) + SUM_W'(elapsed_q);
						end else begin
							sum_q   <= sum_q + SUM_W'(elapsed_q);
							count_q <= count_q + CNT_W'(1);
						end
						head_q <= (head_q == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 :
							head_q + HEAD_W'(1);
					end
				end
				fim_pkg::ST_DIV_START: begin
					if (count_q == '0) begin
						avg_q <= '0;
					end
				end
				fim_pkg::ST_DIV_WAIT: begin
					if (div_done) begin
						avg_q <= div_quot[fim_pkg::TICK_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Window store: the head slot is read ahead of the update, where it holds
	// the oldest interval once the window is full.
	always_ff @(posedge clk) begin
		win_rd_q <= win_mem[head_q];
		if (state_q == fim_pkg::ST_UPDATE && take_q) begin
			win_mem[head_q] <= elapsed_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_elapsed_q <= (kind_q == fim_pkg::KIND_FRAME) ? elapsed_q : '0;
			res_avg_q     <= avg_q;
			res_rate_q    <= rate_q;
			res_total_q   <= total;
			res_stopped_q <= stopped_q;
		end
	end

	fim_divider #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_q),
		.den    (count_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign res.valid         = res_valid_q;
	assign res.elapsed_ticks = res_elapsed_q;
	assign res.average_ticks = res_avg_q;
	assign res.frame_rate    = res_rate_q;
	assign res.total_ticks   = res_total_q;
	assign res.is_stopped    = res_stopped_q;

endmodule

// ----- src/fim_divider.sv -----
// ----------------------------------------------------------------------------
// fim_divider: restoring divider, one quotient bit per cycle
// Pulses done once all NUM_W quotient bits are formed, with the quotient held.
// ----------------------------------------------------------------------------
module fim_divider #(
	parameter int NUM_W = 46,
	parameter int DEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   trial_sub;

	assign trial     = {rem_q, quot_q[NUM_W-1]};
	assign fits      = trial >= {1'b0, den};
	assign trial_sub = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], fits};
			rem_q  <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
